FILE: rtl/pire_pkg.sv
// Shared types and constants for the pulse interval random bit extractor.
`default_nettype none

package pire_pkg;

    localparam int TS_W       = 32;
    localparam int BYTE_W     = 8;
    localparam int BPB_W      = 16;
    localparam int BITPOS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_BLOCK = 1'd1;

    localparam logic [BPB_W-1:0]    BPB_RESET   = 16'd64;
    localparam logic [BYTE_W-1:0]   WHITEN_MASK = 8'hAA;
    localparam logic [BITPOS_W-1:0] LAST_BIT    = 3'd7;

    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic             continuous_mode;
        logic [BPB_W-1:0] bytes_per_block;
    } cfg_t;

    typedef struct packed {
        logic            kind;
        logic [TS_W-1:0] timestamp_us;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/pire_cfg_regs.sv
// Configuration register file: decodes writes into continuous mode and block length.
`default_nettype none

module pire_cfg_regs (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [pire_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [pire_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pire_pkg::cfg_t                     cfg
);

    pire_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.continuous_mode <= 1'b0;
            cfg_reg.bytes_per_block <= pire_pkg::BPB_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pire_pkg::REG_CONTINUOUS_MODE: cfg_reg.continuous_mode <= cfg_data[0];
                pire_pkg::REG_BYTES_PER_BLOCK:
                    cfg_reg.bytes_per_block <= cfg_data[pire_pkg::BPB_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pire_in_stage.sv
// Input register stage: holds one accepted transfer until the core takes it.
`default_nettype none

module pire_in_stage (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire pire_pkg::item_t s_item,
    output logic                item_valid,
    output pire_pkg::item_t     item,
    input  wire                 item_take
);

    logic            valid_reg;
    pire_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pire_core.sv
// Interval comparison, bit assembly, block counting and result register.
`default_nettype none

module pire_core #(
    parameter int TIME_WIDTH = 32
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire pire_pkg::cfg_t                 cfg,
    input  wire                                 item_valid,
    input  wire pire_pkg::item_t                item,
    output logic                                item_take,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [pire_pkg::BYTE_W-1:0]         m_tdata,
    output logic                                m_tlast
);

    logic                            counting_reg, counting_next;
    logic [1:0]                      phase_reg, phase_next;
    logic [TIME_WIDTH-1:0]           first_reg, first_next;
    logic [TIME_WIDTH-1:0]           second_reg, second_next;
    logic [TIME_WIDTH-1:0]           third_reg, third_next;
    logic [pire_pkg::BYTE_W-1:0]     partial_reg, partial_next;
    logic [pire_pkg::BITPOS_W-1:0]   bitpos_reg, bitpos_next;
    logic [pire_pkg::BPB_W-1:0]      done_reg, done_next;

    logic                            out_valid_reg;
    logic [pire_pkg::BYTE_W-1:0]     out_byte_reg;
    logic                            out_last_reg;

    logic                            active;
    logic [TIME_WIDTH-1:0]           t;
    logic [TIME_WIDTH-1:0]           late;
    logic [TIME_WIDTH-1:0]           early;
    logic [pire_pkg::BYTE_W-1:0]     byte_full;
    logic [pire_pkg::BPB_W:0]        done_inc;
    logic                            last;
    logic                            emit;
    logic [pire_pkg::BYTE_W-1:0]     emit_byte;

    assign item_take = item_valid && (!out_valid_reg || m_tready);
    assign active    = counting_reg || cfg.continuous_mode;
    assign t         = TIME_WIDTH'(item.timestamp_us);
    assign late      = t - third_reg;
    assign early     = second_reg - first_reg;
    assign byte_full = partial_reg
                     | (pire_pkg::BYTE_W'(late > early) << bitpos_reg);
    assign done_inc  = {1'b0, done_reg} + (pire_pkg::BPB_W+1)'(1);
    assign last      = done_inc >= {1'b0, cfg.bytes_per_block};
    assign emit_byte = byte_full ^ pire_pkg::WHITEN_MASK;

    always_comb begin
        counting_next = counting_reg;
        phase_next    = phase_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        third_next    = third_reg;
        partial_next  = partial_reg;
        bitpos_next   = bitpos_reg;
        done_next     = done_reg;
        emit          = 1'b0;
        if (item.kind == pire_pkg::KIND_START) begin
            counting_next = 1'b1;
        end else if (active) begin
            case (phase_reg)
                2'd0: begin
                    first_next = t;
                    phase_next = 2'd1;
                end
                2'd1: begin
                    second_next = t;
                    phase_next  = 2'd2;
                end
                2'd2: begin
                    third_next = t;
                    phase_next = 2'd3;
                end
                default: begin
                    phase_next = 2'd0;
                    if (bitpos_reg != pire_pkg::LAST_BIT) begin
                        partial_next = byte_full;
                        bitpos_next  = bitpos_reg + pire_pkg::BITPOS_W'(1);
                    end else begin
                        emit         = 1'b1;
                        partial_next = '0;
                        bitpos_next  = '0;
                        if (last) begin
                            done_next     = '0;
                            counting_next = 1'b0;
                        end else begin
                            done_next = done_inc[pire_pkg::BPB_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counting_reg  <= 1'b0;
            phase_reg     <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            third_reg     <= '0;
            partial_reg   <= '0;
            bitpos_reg    <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (item_take) begin
                counting_reg <= counting_next;
                phase_reg    <= phase_next;
                first_reg    <= first_next;
                second_reg   <= second_next;
                third_reg    <= third_next;
                partial_reg  <= partial_next;
                bitpos_reg   <= bitpos_next;
                done_reg     <= done_next;
            end
            if (item_take && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && emit) begin
            out_byte_reg <= emit_byte;
            out_last_reg <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/pulse_interval_random_bit_extractor_top.sv
// Top level of the pulse interval random bit extractor.
// Takes one transfer per cycle on the s_ side: a detector pulse with its timestamp or a
// start request. Every four pulses while counting or in continuous mode give one bit (last
// interval longer than first interval); eight bits make a byte that leaves on the m_ side
// XORed with 0xAA, with tlast on the final byte of a block. An accepted transfer passes an
// input register and is then resolved into the result register; the sustained rate is one
// transfer per cycle, and the only thing that slows intake is a result held in the output
// register by a low m_tready. Configuration writes complete at once and belong to idle
// periods.
`default_nettype none

module pulse_interval_random_bit_extractor_top #(
    parameter int TIME_WIDTH = 32
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [pire_pkg::TS_W-1:0]           s_tdata,   // [31:0] timestamp_us
    input  wire                                 s_tuser,   // [0] kind
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [pire_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] random_byte
    output logic                                m_tlast,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [pire_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [pire_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pire_pkg::cfg_t  cfg;
    pire_pkg::item_t s_item;
    pire_pkg::item_t item;
    logic            item_valid;
    logic            item_take;

    assign s_item.kind         = s_tuser;
    assign s_item.timestamp_us = s_tdata;

    pire_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pire_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    pire_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/pire_checker.sv
// Port-level checker for the extractor top level, attached by bind.
`default_nettype none

module pire_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [pire_pkg::BYTE_W-1:0]       m_tdata,
    input wire                              m_tlast,
    input wire                              cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind pulse_interval_random_bit_extractor_top pire_checker u_pire_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

FILE: tb/pulse_interval_random_bit_extractor_top_test.sv
// Self-checking testbench for the pulse interval random bit extractor top level.
`timescale 1ns / 1ps

typedef struct packed {
    logic [pire_pkg::BYTE_W-1:0] value;
    logic                        block_end;
} rand_byte_t;

class random_byte_scoreboard;
    logic                          cont_mode;
    logic [pire_pkg::BPB_W-1:0]    block_len;
    logic                          armed;
    logic [1:0]                    phase;
    logic [pire_pkg::TS_W-1:0]     t0;
    logic [pire_pkg::TS_W-1:0]     t1;
    logic [pire_pkg::TS_W-1:0]     t2;
    logic [pire_pkg::BYTE_W-1:0]   acc;
    logic [pire_pkg::BITPOS_W-1:0] bitpos;
    logic [pire_pkg::BPB_W-1:0]    done_cnt;
    rand_byte_t                    expected_bytes[$];
    int                            errors;
    int                            bytes_predicted;

    function new();
        cont_mode       = 1'b0;
        block_len       = pire_pkg::BPB_RESET;
        armed           = 1'b0;
        phase           = 2'd0;
        t0              = '0;
        t1              = '0;
        t2              = '0;
        acc             = '0;
        bitpos          = '0;
        done_cnt        = '0;
        errors          = 0;
        bytes_predicted = 0;
    endfunction

    function bit is_active();
        return armed || cont_mode;
    endfunction

    function void set_reg(logic [pire_pkg::CFG_IDX_W-1:0] idx,
                          logic [pire_pkg::CFG_DATA_W-1:0] val);
        if (idx == pire_pkg::REG_CONTINUOUS_MODE) begin
            cont_mode = val[0];
        end else if (idx == pire_pkg::REG_BYTES_PER_BLOCK) begin
            block_len = val[pire_pkg::BPB_W-1:0];
        end
    endfunction

    // Predicts the effect of one accepted input transfer.
    function void absorb_event(logic kind, logic [pire_pkg::TS_W-1:0] ts);
        logic [pire_pkg::TS_W-1:0] late;
        logic [pire_pkg::TS_W-1:0] early;
        logic [pire_pkg::BPB_W:0]  nxt;
        rand_byte_t                rb;
        if (kind == pire_pkg::KIND_START) begin
            armed = 1'b1;
            return;
        end
        if (!is_active()) return;
        case (phase)
            2'd0: begin
                t0    = ts;
                phase = 2'd1;
            end
            2'd1: begin
                t1    = ts;
                phase = 2'd2;
            end
            2'd2: begin
                t2    = ts;
                phase = 2'd3;
            end
            default: begin
                phase = 2'd0;
                late  = ts - t2;
                early = t1 - t0;
                if (late > early) acc[bitpos] = 1'b1;
                if (bitpos != pire_pkg::LAST_BIT) begin
                    bitpos = bitpos + 1'b1;
                end else begin
                    nxt          = {1'b0, done_cnt} + 1'b1;
                    rb.value     = acc ^ pire_pkg::WHITEN_MASK;
                    rb.block_end = (nxt >= {1'b0, block_len});
                    acc          = '0;
                    bitpos       = '0;
                    if (rb.block_end) begin
                        done_cnt = '0;
                        armed    = 1'b0;
                    end else begin
                        done_cnt = nxt[pire_pkg::BPB_W-1:0];
                    end
                    expected_bytes.push_back(rb);
                    bytes_predicted++;
                end
            end
        endcase
    endfunction

    function void check_byte(logic [pire_pkg::BYTE_W-1:0] value, logic block_end);
        rand_byte_t rb;
        if (expected_bytes.size() == 0) begin
            $error("unexpected result: random_byte %02h block_end %0b", value, block_end);
            errors++;
            return;
        end
        rb = expected_bytes.pop_front();
        if (value !== rb.value) begin
            $error("random_byte: expected %02h, actual %02h", rb.value, value);
            errors++;
        end
        if (block_end !== rb.block_end) begin
            $error("block_end: expected %0b, actual %0b", rb.block_end, block_end);
            errors++;
        end
    endfunction
endclass

module pulse_interval_random_bit_extractor_top_test;

    localparam int IDLE_LIMIT = 4000;
    localparam int ITEM_TARGET = 1100;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    wire                             s_tready;
    logic [pire_pkg::TS_W-1:0]       s_tdata   = '0;   // [31:0] timestamp_us
    logic                            s_tuser   = 1'b0; // [0] kind
    wire                             m_tvalid;
    logic                            m_tready  = 1'b0;
    wire  [pire_pkg::BYTE_W-1:0]     m_tdata;          // [7:0] random_byte
    wire                             m_tlast;
    logic                            cfg_valid = 1'b0;
    wire                             cfg_ready;
    logic [pire_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pire_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                            calm      = 1'b0;
    logic [pire_pkg::TS_W-1:0]       now_us    = '0;
    int                              idle_cycles = 0;
    int                              done_items  = 0;

    random_byte_scoreboard sb = new();

    pulse_interval_random_bit_extractor_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 18);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** pulse_interval_random_bit_extractor_top: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [pire_pkg::TS_W-1:0] ts);
        while (!calm && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ts;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.absorb_event(kind, ts);
        done_items++;
    endtask

    // Both registers go out back to back with valid held high.
    task automatic set_config(input logic cont, input logic [pire_pkg::BPB_W-1:0] bpb);
        cfg_valid <= 1'b1;
        cfg_index <= pire_pkg::REG_CONTINUOUS_MODE;
        cfg_data  <= {{(pire_pkg::CFG_DATA_W-1){1'b0}}, cont};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(pire_pkg::REG_CONTINUOUS_MODE, {{(pire_pkg::CFG_DATA_W-1){1'b0}}, cont});
        cfg_index <= pire_pkg::REG_BYTES_PER_BLOCK;
        cfg_data  <= bpb;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(pire_pkg::REG_BYTES_PER_BLOCK, bpb);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Mix of small, zero, huge and random deltas; near-ties on the closing pulse.
    function automatic logic [pire_pkg::TS_W-1:0] next_stamp();
        int unsigned               r;
        logic [pire_pkg::TS_W-1:0] jitter;
        r      = $urandom_range(0, 99);
        jitter = $urandom_range(0, 2);
        if (sb.phase == 2'd3 && r < 25) begin
            now_us = sb.t2 + (sb.t1 - sb.t0) + jitter - 1'b1;
        end else if (r < 35) begin
            now_us = $urandom;
        end else if (r < 45) begin
            now_us = now_us;
        end else if (r < 80) begin
            now_us = now_us + $urandom_range(1, 1000);
        end else begin
            now_us = now_us + $urandom;
        end
        return now_us;
    endfunction

    task automatic send_pulses(input int n);
        repeat (n) send_item(pire_pkg::KIND_PULSE, next_stamp());
    endtask

    task automatic random_phase();
        int unsigned                r;
        int                         len;
        logic                       cont;
        logic [pire_pkg::BPB_W-1:0] bpb;
        logic                       kind;
        r    = $urandom_range(0, 99);
        cont = ($urandom_range(0, 99) < 30);
        if (r < 10)      bpb = '0;
        else if (r < 25) bpb = 16'd1;
        else if (r < 75) bpb = pire_pkg::BPB_W'($urandom_range(2, 4));
        else if (r < 90) bpb = 16'hFFFF;
        else             bpb = pire_pkg::BPB_W'($urandom);
        drain();
        set_config(cont, bpb);
        len = $urandom_range(40, 160);
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (!sb.is_active()) kind = (r < 60) ? pire_pkg::KIND_START : pire_pkg::KIND_PULSE;
            else                 kind = (r < 3) ? pire_pkg::KIND_START : pire_pkg::KIND_PULSE;
            calm <= (done_items >= 500 && done_items < 700);
            send_item(kind, (kind == pire_pkg::KIND_START) ? pire_pkg::TS_W'($urandom)
                                                            : next_stamp());
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pulses while idle are dropped, repeated start is harmless
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0000);
        send_item(pire_pkg::KIND_PULSE, 32'hFFFF_FFFF);
        send_item(pire_pkg::KIND_START, 32'h0000_0000);
        send_item(pire_pkg::KIND_START, 32'hFFFF_FFFF);
        // equal intervals across the wrap
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0000);
        send_item(pire_pkg::KIND_PULSE, 32'h0000_000A);
        send_item(pire_pkg::KIND_PULSE, 32'hFFFF_FFF0);
        send_item(pire_pkg::KIND_PULSE, 32'hFFFF_FFFA);
        // longer late interval, both wrapping
        send_item(pire_pkg::KIND_PULSE, 32'hFFFF_FFFE);
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0001);
        send_item(pire_pkg::KIND_PULSE, 32'hFFFF_FFFF);
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0003);
        // maximum intervals, tied
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0000);
        send_item(pire_pkg::KIND_PULSE, 32'hFFFF_FFFF);
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0000);
        send_item(pire_pkg::KIND_PULSE, 32'hFFFF_FFFF);
        // zero late interval
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0001);
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0002);
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0007);
        send_item(pire_pkg::KIND_PULSE, 32'h0000_0007);

        // one-byte blocks, then pulses after the block end are dropped
        drain();
        set_config(1'b0, 16'd1);
        send_item(pire_pkg::KIND_START, $urandom);
        send_pulses(40);

        // zero block length acts as one
        drain();
        set_config(1'b0, 16'd0);
        send_item(pire_pkg::KIND_START, $urandom);
        send_pulses(32);
        send_pulses(6);

        // continuous mode, then cleared with partial bits held
        drain();
        set_config(1'b1, 16'd3);
        send_pulses(70);
        drain();
        set_config(1'b0, 16'd3);
        send_pulses(5);
        send_item(pire_pkg::KIND_START, $urandom);
        send_pulses(30);

        // long block, length lowered below the bytes already done
        drain();
        set_config(1'b0, 16'hFFFF);
        send_item(pire_pkg::KIND_START, $urandom);
        send_pulses(64);
        drain();
        set_config(1'b0, 16'd1);
        send_pulses(32);

        while (done_items < ITEM_TARGET) random_phase();

        calm <= 1'b0;
        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
            $display("** pulse_interval_random_bit_extractor_top: PASSED **");
        end else begin
            $display("** pulse_interval_random_bit_extractor_top: FAILED **");
        end
        $finish;
    end

endmodule
